/* hw/rtl/page_frame_lru_manager_defines.svh */
// ---------------------------------------------------------------------------
// page_frame_lru_manager_defines
// Assertion macros for the page frame manager RTL.
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_LRU_MANAGER_DEFINES_SVH
`define PAGE_FRAME_LRU_MANAGER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PFLM_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define PFLM_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* hw/rtl/pflm_pkg.sv */
// ---------------------------------------------------------------------------
// pflm_pkg
// Types and constants of the page frame LRU manager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pflm_pkg;
  localparam int FRAMES  = 16;
  localparam int IDX_W   = $clog2(FRAMES);
  localparam int AGE_W   = IDX_W;
  localparam int CNT_W   = IDX_W + 1;
  localparam int PAGE_W  = 16;
  localparam int PIN_W   = 8;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 3;
  localparam int FRAME_W = 4;
  localparam int DCNT_W  = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_FETCH  = 3'd0,
    CMD_NEW    = 3'd1,
    CMD_UNPIN  = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_FLUSH  = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_BEYOND    = 3'd1,
    STAT_FREED     = 3'd2,
    STAT_NO_VICTIM = 3'd3,
    STAT_NOT_RES   = 3'd4,
    STAT_PINNED    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_TOUCH,
    UPD_INC_ALL,
    UPD_DROP
  } upd_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_UPD,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              dirty;
    logic [PIN_W-1:0]  pins;
    logic [AGE_W-1:0]  age;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] page_id;
    logic [DCNT_W-1:0] disk_page_count;
    logic              page_is_free;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  frame;
    logic              hit;
    logic              read_request;
    logic              write_back;
    logic [PAGE_W-1:0] write_back_page;
    logic              release_on_disk;
    logic              zero_frame;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              we;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic              vset;
    logic              vclr;
    logic [IDX_W-1:0]  vidx;
  } mem_req_t;
endpackage
`default_nettype wire

/* hw/rtl/page_frame_lru_manager.sv */
// ---------------------------------------------------------------------------
// page_frame_lru_manager
// Buffer pool frame manager with LRU replacement and pin counts.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request (cmd, page_id,
//   disk_page_count, page_is_free). Result channel out_valid/out_ready
//   carries one answer per request: status, frame, hit and disk actions.
//   A request walks the frame table in a memory with a registered read:
//   a scan pass, a decision step, and for requests that change state a
//   read-modify-write pass, then a step that posts the result. One
//   request is in work at a time: a new request is taken only after
//   the last one has posted its result.
//   The result sits in an output register, so the next request is taken
//   while it waits; if the receiver stalls, the finished request waits
//   in its last step until the register frees.
//   Reset clears all frame valid bits: every frame is free afterward.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module page_frame_lru_manager (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [15:0] in_page_id,
  input  wire logic [16:0] in_disk_page_count,
  input  wire logic        in_page_is_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [3:0]       out_frame_index,
  output logic             out_hit,
  output logic             out_read_request,
  output logic             out_write_back,
  output logic [15:0]      out_write_back_page,
  output logic             out_release_on_disk,
  output logic             out_zero_frame
);
  import pflm_pkg::*;

  req_t              req;
  res_t              res;
  logic              res_valid;
  logic              slot_free;
  mem_req_t          mreq;
  entry_t            rd_data;
  logic [FRAMES-1:0] valid;
  logic              out_valid_r;
  res_t              out_res_r;

  assign req.cmd             = in_cmd;
  assign req.page_id         = in_page_id;
  assign req.disk_page_count = in_disk_page_count;
  assign req.page_is_free    = in_page_is_free;

  assign slot_free = !out_valid_r || out_ready;

  pflm_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (in_valid),
    .req_ready     (in_ready),
    .req           (req),
    .res_valid     (res_valid),
    .res_slot_free (slot_free),
    .res           (res),
    .mreq          (mreq),
    .rd_data       (rd_data),
    .valid         (valid)
  );

  pflm_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .mreq    (mreq),
    .rd_data (rd_data),
    .valid   (valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_frame_index     = FRAME_W'(out_res_r.frame);
  assign out_hit             = out_res_r.hit;
  assign out_read_request    = out_res_r.read_request;
  assign out_write_back      = out_res_r.write_back;
  assign out_write_back_page = out_res_r.write_back_page;
  assign out_release_on_disk = out_res_r.release_on_disk;
  assign out_zero_frame      = out_res_r.zero_frame;
endmodule
`default_nettype wire

/* hw/rtl/pflm_store.sv */
// ---------------------------------------------------------------------------
// pflm_store
// Frame table memory (registered read) plus per-frame valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pflm_store (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire pflm_pkg::mem_req_t       mreq,
  output pflm_pkg::entry_t              rd_data,
  output logic [pflm_pkg::FRAMES-1:0]   valid
);
  import pflm_pkg::*;

  entry_t              mem [FRAMES];
  entry_t              rd_data_r;
  logic [FRAMES-1:0]   valid_r;
  logic [FRAMES-1:0]   valid_nxt;

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rd_data_r <= mem[mreq.rd_addr];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (mreq.vset) begin
      valid_nxt[mreq.vidx] = 1'b1;
    end
    if (mreq.vclr) begin
      valid_nxt[mreq.vidx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign rd_data = rd_data_r;
  assign valid   = valid_r;
endmodule
`default_nettype wire

/* hw/rtl/pflm_ctrl.sv */
// ---------------------------------------------------------------------------
// pflm_ctrl
// Request sequencer: scan pass, decision, read-modify-write rank pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "page_frame_lru_manager_defines.svh"
module pflm_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     req_valid,
  output logic                          req_ready,
  input  wire pflm_pkg::req_t           req,
  output logic                          res_valid,
  input  wire logic                     res_slot_free,
  output pflm_pkg::res_t                res,
  output pflm_pkg::mem_req_t            mreq,
  input  wire pflm_pkg::entry_t         rd_data,
  input  wire logic [pflm_pkg::FRAMES-1:0] valid
);
  import pflm_pkg::*;

  typedef struct packed {
    res_t              res;
    logic              do_upd;
    logic              tgt_wr;
    logic [IDX_W-1:0]  tgt;
    entry_t            tgt_ent;
    upd_mode_t         mode;
    logic [AGE_W-1:0]  ref_age;
    logic              vset;
    logic              vclr;
    logic [IDX_W-1:0]  vidx;
  } plan_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_idx_r;
  req_t              req_r;
  logic              found_r, free_r, vic_r;
  logic [IDX_W-1:0]  fidx_r, freeidx_r, vidx_r;
  entry_t            fent_r, vent_r;
  plan_t             plan_r, plan_nxt;
  entry_t            upd_ent;
  logic              pid_ok;
  logic              rd_is_valid;

  assign rd_is_valid = valid[rd_idx_r];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mreq      = '0;
    req_ready = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
        end
      end
      S_SCAN, S_UPD: begin
        if (cnt_r < CNT_W'(FRAMES)) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = cnt_r[IDX_W-1:0];
          cnt_nxt      = cnt_r + 1'b1;
        end
        if (state_r == S_UPD && rd_vld_r) begin
          mreq.we      = 1'b1;
          mreq.wr_addr = rd_idx_r;
          mreq.wr_data = upd_ent;
        end
        if (cnt_r == CNT_W'(FRAMES) && rd_vld_r) begin
          state_nxt = (state_r == S_SCAN) ? S_DECIDE : S_DONE;
        end
      end
      S_DECIDE: begin
        cnt_nxt   = '0;
        state_nxt = plan_nxt.do_upd ? S_UPD : S_DONE;
      end
      S_DONE: begin
        if (res_slot_free) begin
          res_valid  = 1'b1;
          mreq.vset  = plan_r.vset;
          mreq.vclr  = plan_r.vclr;
          mreq.vidx  = plan_r.vidx;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rd_vld_r <= mreq.rd_en;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    rd_idx_r <= mreq.rd_addr;
    if (state_r == S_IDLE && req_valid) begin
      req_r   <= req;
      found_r <= 1'b0;
      free_r  <= 1'b0;
      vic_r   <= 1'b0;
    end
    if (state_r == S_SCAN && rd_vld_r) begin
      if (rd_is_valid && rd_data.page == req_r.page_id && !found_r) begin
        found_r <= 1'b1;
        fidx_r  <= rd_idx_r;
        fent_r  <= rd_data;
      end
      if (!rd_is_valid && !free_r) begin
        free_r    <= 1'b1;
        freeidx_r <= rd_idx_r;
      end
      if (rd_is_valid && rd_data.pins == '0 && (!vic_r || rd_data.age > vent_r.age)) begin
        vic_r  <= 1'b1;
        vidx_r <= rd_idx_r;
        vent_r <= rd_data;
      end
    end
    if (state_r == S_DECIDE) begin
      plan_r <= plan_nxt;
    end
  end

  // decision
  assign pid_ok = {1'b0, req_r.page_id} < req_r.disk_page_count;

  always_comb begin
    plan_nxt = '0;
    case (req_r.cmd)
      CMD_FETCH, CMD_NEW: begin
        if (!pid_ok) begin
          plan_nxt.res.status = STAT_BEYOND;
        end else if (req_r.page_is_free) begin
          plan_nxt.res.status = STAT_FREED;
        end else if (found_r) begin
          plan_nxt.res.hit        = 1'b1;
          plan_nxt.res.frame      = fidx_r;
          plan_nxt.res.zero_frame = (req_r.cmd == CMD_NEW);
          plan_nxt.do_upd         = 1'b1;
          plan_nxt.tgt_wr         = 1'b1;
          plan_nxt.tgt            = fidx_r;
          plan_nxt.tgt_ent        = fent_r;
          plan_nxt.tgt_ent.age    = '0;
          plan_nxt.tgt_ent.dirty  = fent_r.dirty | (req_r.cmd == CMD_NEW);
          if (fent_r.pins != '1) begin
            plan_nxt.tgt_ent.pins = fent_r.pins + 1'b1;
          end
          plan_nxt.mode    = UPD_TOUCH;
          plan_nxt.ref_age = fent_r.age;
        end else if (free_r || vic_r) begin
          plan_nxt.res.frame        = free_r ? freeidx_r : vidx_r;
          plan_nxt.res.read_request = (req_r.cmd == CMD_FETCH);
          plan_nxt.res.zero_frame   = (req_r.cmd == CMD_NEW);
          plan_nxt.do_upd           = 1'b1;
          plan_nxt.tgt_wr           = 1'b1;
          plan_nxt.tgt              = free_r ? freeidx_r : vidx_r;
          plan_nxt.tgt_ent.page     = req_r.page_id;
          plan_nxt.tgt_ent.dirty    = (req_r.cmd == CMD_NEW);
          plan_nxt.tgt_ent.pins     = PIN_W'(1);
          plan_nxt.tgt_ent.age      = '0;
          if (free_r) begin
            plan_nxt.mode = UPD_INC_ALL;
            plan_nxt.vset = 1'b1;
            plan_nxt.vidx = freeidx_r;
          end else begin
            plan_nxt.mode                = UPD_TOUCH;
            plan_nxt.ref_age             = vent_r.age;
            plan_nxt.res.write_back      = vent_r.dirty;
            plan_nxt.res.write_back_page = vent_r.dirty ? vent_r.page : '0;
          end
        end else begin
          plan_nxt.res.status = STAT_NO_VICTIM;
        end
      end
      CMD_UNPIN, CMD_FLUSH: begin
        if (!found_r) begin
          plan_nxt.res.status = STAT_NOT_RES;
        end else begin
          plan_nxt.res.frame           = fidx_r;
          plan_nxt.res.hit             = 1'b1;
          plan_nxt.res.write_back      = (req_r.cmd == CMD_FLUSH) | fent_r.dirty;
          plan_nxt.res.write_back_page =
            ((req_r.cmd == CMD_FLUSH) | fent_r.dirty) ? req_r.page_id : '0;
          plan_nxt.do_upd        = 1'b1;
          plan_nxt.tgt_wr        = 1'b1;
          plan_nxt.tgt           = fidx_r;
          plan_nxt.tgt_ent       = fent_r;
          plan_nxt.tgt_ent.dirty = 1'b0;
          if (req_r.cmd == CMD_UNPIN && fent_r.pins != '0) begin
            plan_nxt.tgt_ent.pins = fent_r.pins - 1'b1;
          end
          plan_nxt.mode = UPD_NONE;
        end
      end
      CMD_DELETE: begin
        if (found_r && fent_r.pins != '0) begin
          plan_nxt.res.status = STAT_PINNED;
          plan_nxt.res.frame  = fidx_r;
          plan_nxt.res.hit    = 1'b1;
        end else begin
          if (found_r) begin
            plan_nxt.res.frame           = fidx_r;
            plan_nxt.res.hit             = 1'b1;
            plan_nxt.res.write_back      = fent_r.dirty;
            plan_nxt.res.write_back_page = fent_r.dirty ? req_r.page_id : '0;
            plan_nxt.do_upd              = 1'b1;
            plan_nxt.mode                = UPD_DROP;
            plan_nxt.ref_age             = fent_r.age;
            plan_nxt.vclr                = 1'b1;
            plan_nxt.vidx                = fidx_r;
          end
          if (pid_ok) begin
            plan_nxt.res.release_on_disk = 1'b1;
          end else if (!found_r) begin
            plan_nxt.res.status = STAT_NOT_RES;
          end
        end
      end
      default: plan_nxt = '0;
    endcase
  end

  // rank update of one entry
  always_comb begin
    upd_ent = rd_data;
    if (plan_r.tgt_wr && rd_idx_r == plan_r.tgt) begin
      upd_ent = plan_r.tgt_ent;
    end else if (rd_is_valid) begin
      case (plan_r.mode)
        UPD_TOUCH: begin
          if (rd_data.age < plan_r.ref_age) upd_ent.age = rd_data.age + 1'b1;
        end
        UPD_INC_ALL: upd_ent.age = rd_data.age + 1'b1;
        UPD_DROP: begin
          if (rd_data.age > plan_r.ref_age) upd_ent.age = rd_data.age - 1'b1;
        end
        default: upd_ent = rd_data;
      endcase
    end
  end

  assign res = plan_r.res;

  `PFLM_ASSERT_IMP(a_res_in_done, clk, rst_n, res_valid, state_r == S_DONE)
  `PFLM_ASSERT_IMP(a_we_in_upd, clk, rst_n, mreq.we, state_r == S_UPD)
  `PFLM_ASSERT_NXT(a_decide_exit, clk, rst_n, state_r == S_DECIDE,
    state_r == S_UPD || state_r == S_DONE)
  `PFLM_ASSERT_IMP(a_read_is_miss, clk, rst_n, res_valid && res.read_request,
    !res.hit && res.status == STAT_OK)
endmodule
`default_nettype wire
